### rtl/ctm_pkg.sv
package ctm_pkg;

    // default table bounds
    localparam int CTM_MAX_CARD = 64;
    localparam int CTM_MAX_Z    = 4096;

    // payload widths
    localparam int CTM_CELL_W     = 32;
    localparam int CTM_SUM_W      = 44;
    localparam int CTM_IDX_W      = 18;
    // buffer address field, wide enough for a MAX_CARD of up to 1024
    localparam int CTM_ADDR_W     = 10;
    localparam int CTM_CFG_IDX_W  = 4;
    localparam int CTM_CFG_DATA_W = 16;
    localparam int CTM_MODE_W     = 2;
    localparam int CTM_XYC_W      = 7;
    localparam int CTM_ZC_W       = 13;

    typedef enum logic [CTM_MODE_W-1:0] {
        MODE_SUM_X  = 2'd0,
        MODE_SUM_Y  = 2'd1,
        MODE_SUM_XY = 2'd2,
        MODE_BAD    = 2'd3
    } t_mode;

    typedef enum logic [CTM_CFG_IDX_W-1:0] {
        REG_MODE   = 4'd0,
        REG_X_CARD = 4'd1,
        REG_Y_CARD = 4'd2,
        REG_Z_CARD = 4'd3
    } t_reg;

    // work the back end does for one cell
    typedef enum logic [1:0] {
        OP_SUM = 2'd0,   // running accumulator
        OP_BUF = 2'd1,   // per-x partial sum buffer
        OP_ERR = 2'd2    // unsupported mode, error result
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  emit;       // this cell produces a result
        logic                  first;      // y == 0: buffer entry starts fresh
        logic                  last_cell;  // final cell of reduced table
        logic                  table_end;  // final cell of input table
        logic [CTM_ADDR_W-1:0] addr;
        logic [CTM_IDX_W-1:0]  index;
        logic [CTM_CELL_W-1:0] count;
    } t_cmd;

endpackage

### rtl/ctm_intf.sv
interface ctm_cell_if import ctm_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CTM_CELL_W-1:0] cell_count;

    modport source (output valid, output cell_count, input ready);
    modport sink   (input valid, input cell_count, output ready);
endinterface

interface ctm_result_if import ctm_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CTM_SUM_W-1:0] marginal_sum;
    logic [CTM_IDX_W-1:0] out_index;
    logic                 last_cell;
    logic                 error;

    modport source (output valid, output marginal_sum, output out_index,
                    output last_cell, output error, input ready);
    modport sink   (input valid, input marginal_sum, input out_index,
                    input last_cell, input error, output ready);
endinterface

interface ctm_cfg_if import ctm_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic [CTM_CFG_IDX_W-1:0]  index;
    logic [CTM_CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ctm_ram.sv
module ctm_ram import ctm_pkg::*; #(
    parameter int  WIDTH = CTM_SUM_W,
    parameter int  DEPTH = CTM_MAX_CARD,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ctm_front.sv
module ctm_front import ctm_pkg::*; #(
    parameter int MAX_CARD = CTM_MAX_CARD,
    parameter int MAX_Z    = CTM_MAX_Z
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctm_cell_if.sink   i_cell,
    ctm_cfg_if.sink    i_cfg,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd,
    output logic       o_restart
);

    localparam int PW = $clog2(MAX_CARD);
    localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

    // last valid position for a card, with 0 read as 1 and clamp to hi
    function automatic int card_last(input int card, input int hi);
        int res;
        if (card == 0) begin
            res = 0;
        end else if (card > hi) begin
            res = hi - 1;
        end else begin
            res = card - 1;
        end
        return res;
    endfunction

    t_mode                r_mode;
    logic [CTM_XYC_W-1:0] r_x_card;
    logic [CTM_XYC_W-1:0] r_y_card;
    logic [CTM_ZC_W-1:0]  r_z_card;
    logic [PW-1:0]        r_x_pos, n_x_pos;
    logic [PW-1:0]        r_y_pos, n_y_pos;
    logic [ZW-1:0]        r_z_pos, n_z_pos;
    logic [CTM_IDX_W-1:0] r_emit_idx, n_emit_idx;

    logic [PW-1:0] x_last;
    logic [PW-1:0] y_last;
    logic [ZW-1:0] z_last;
    logic          xl, yl, zl;
    logic          accept;
    logic          cfg_wr;
    t_cmd          cmd;

    assign x_last = PW'(card_last(int'(r_x_card), MAX_CARD));
    assign y_last = PW'(card_last(int'(r_y_card), MAX_CARD));
    assign z_last = ZW'(card_last(int'(r_z_card), MAX_Z));

    assign xl = (r_x_pos == x_last);
    assign yl = (r_y_pos == y_last);
    assign zl = (r_z_pos == z_last);

    // a cell is never taken in the cycle of a register write
    assign i_cfg.ready  = 1'b1;
    assign cfg_wr       = i_cfg.valid;
    assign i_cell.ready = !i_q_full && !cfg_wr;
    assign accept       = i_cell.valid && !i_q_full && !cfg_wr;

    // classify the cell
    always_comb begin
        cmd           = '0;
        cmd.first     = (r_y_pos == '0);
        cmd.last_cell = xl && yl && zl;
        cmd.table_end = xl && yl && zl;
        cmd.addr      = CTM_ADDR_W'(r_x_pos);
        cmd.index     = r_emit_idx;
        cmd.count     = i_cell.cell_count;
        case (r_mode)
            MODE_SUM_X: begin
                cmd.op   = OP_SUM;
                cmd.emit = xl;
            end
            MODE_SUM_Y: begin
                cmd.op   = OP_BUF;
                cmd.emit = yl;
            end
            MODE_SUM_XY: begin
                cmd.op   = OP_SUM;
                cmd.emit = xl && yl;
            end
            default: begin
                cmd.op   = OP_ERR;
                cmd.emit = 1'b1;
            end
        endcase
    end

    // table walk
    always_comb begin
        n_x_pos    = r_x_pos;
        n_y_pos    = r_y_pos;
        n_z_pos    = r_z_pos;
        n_emit_idx = r_emit_idx;
        if (cfg_wr) begin
            n_x_pos    = '0;
            n_y_pos    = '0;
            n_z_pos    = '0;
            n_emit_idx = '0;
        end else if (accept) begin
            if (cmd.emit && (cmd.op != OP_ERR)) begin
                n_emit_idx = r_emit_idx + CTM_IDX_W'(1);
            end
            if (xl) begin
                n_x_pos = '0;
                if (yl) begin
                    n_y_pos = '0;
                    if (zl) begin
                        n_z_pos    = '0;
                        n_emit_idx = '0;
                    end else begin
                        n_z_pos = r_z_pos + ZW'(1);
                    end
                end else begin
                    n_y_pos = r_y_pos + PW'(1);
                end
            end else begin
                n_x_pos = r_x_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_SUM_X;
            r_x_card   <= CTM_XYC_W'(1);
            r_y_card   <= CTM_XYC_W'(1);
            r_z_card   <= CTM_ZC_W'(1);
            r_x_pos    <= '0;
            r_y_pos    <= '0;
            r_z_pos    <= '0;
            r_emit_idx <= '0;
        end else begin
            r_x_pos    <= n_x_pos;
            r_y_pos    <= n_y_pos;
            r_z_pos    <= n_z_pos;
            r_emit_idx <= n_emit_idx;
            if (cfg_wr) begin
                if (i_cfg.index == REG_MODE) begin
                    r_mode <= t_mode'(i_cfg.data[CTM_MODE_W-1:0]);
                end
                if (i_cfg.index == REG_X_CARD) begin
                    r_x_card <= i_cfg.data[CTM_XYC_W-1:0];
                end
                if (i_cfg.index == REG_Y_CARD) begin
                    r_y_card <= i_cfg.data[CTM_XYC_W-1:0];
                end
                if (i_cfg.index == REG_Z_CARD) begin
                    r_z_card <= i_cfg.data[CTM_ZC_W-1:0];
                end
            end
        end
    end

    assign o_push    = accept && !cfg_wr;
    assign o_cmd     = cmd;
    assign o_restart = cfg_wr;

endmodule

### rtl/ctm_queue.sv
module ctm_queue import ctm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    // two entries: enough to take cells without a gap while the back end flows
    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    logic push;
    logic pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/ctm_back.sv
module ctm_back import ctm_pkg::*; #(
    parameter int MAX_CARD = CTM_MAX_CARD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    ctm_result_if.source o_res
);

    localparam int AW = $clog2(MAX_CARD);

    t_cmd                 r_ex;
    logic                 r_ex_valid;
    logic [CTM_SUM_W-1:0] r_run;
    logic                 r_fwd;
    logic [CTM_SUM_W-1:0] r_fwd_data;

    logic                 r_out_valid;
    logic [CTM_SUM_W-1:0] r_out_sum;
    logic [CTM_IDX_W-1:0] r_out_idx;
    logic                 r_out_last;
    logic                 r_out_err;

    logic                 ex_result;
    logic                 ex_adv;
    logic                 pop;
    logic [CTM_SUM_W-1:0] cell_ext;
    logic [CTM_SUM_W-1:0] rdata;
    logic [CTM_SUM_W-1:0] old_val;
    logic [CTM_SUM_W-1:0] buf_val;
    logic [CTM_SUM_W-1:0] sum_val;
    logic                 buf_we;
    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;

    assign ex_result = r_ex.emit;
    assign ex_adv    = r_ex_valid && (!ex_result || !r_out_valid || o_res.ready);
    assign pop       = i_q_valid && (!r_ex_valid || ex_adv);
    assign o_pop     = pop;

    assign raddr    = i_q_cmd.addr[AW-1:0];
    assign waddr    = r_ex.addr[AW-1:0];
    assign cell_ext = CTM_SUM_W'(r_ex.count);
    // entry written back in the cycle this one was read: take the new value
    assign old_val  = r_fwd ? r_fwd_data : rdata;
    assign buf_val  = r_ex.first ? cell_ext : old_val + cell_ext;
    assign sum_val  = r_run + cell_ext;
    assign buf_we   = ex_adv && (r_ex.op == OP_BUF);

    ctm_ram #(
        .WIDTH (CTM_SUM_W),
        .DEPTH (MAX_CARD)
    ) u_partial (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (waddr),
        .i_wdata (buf_val),
        .i_re    (pop),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= '0;
            r_fwd       <= 1'b0;
        end else begin
            if (pop) begin
                r_ex_valid <= 1'b1;
                r_fwd      <= buf_we && (waddr == raddr);
            end else if (ex_adv) begin
                r_ex_valid <= 1'b0;
            end

            if (ex_adv && ex_result) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_restart) begin
                r_run <= '0;
            end else if (ex_adv) begin
                if (r_ex.table_end) begin
                    r_run <= '0;
                end else if (r_ex.op == OP_SUM) begin
                    r_run <= r_ex.emit ? '0 : sum_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_ex       <= i_q_cmd;
            r_fwd_data <= buf_val;
        end
        if (ex_adv && ex_result) begin
            case (r_ex.op)
                OP_SUM: begin
                    r_out_sum  <= sum_val;
                    r_out_idx  <= r_ex.index;
                    r_out_last <= r_ex.last_cell;
                    r_out_err  <= 1'b0;
                end
                OP_BUF: begin
                    r_out_sum  <= buf_val;
                    r_out_idx  <= r_ex.index;
                    r_out_last <= r_ex.last_cell;
                    r_out_err  <= 1'b0;
                end
                default: begin
                    r_out_sum  <= '0;
                    r_out_idx  <= '0;
                    r_out_last <= 1'b0;
                    r_out_err  <= 1'b1;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.marginal_sum = r_out_sum;
    assign o_res.out_index    = r_out_idx;
    assign o_res.last_cell    = r_out_last;
    assign o_res.error        = r_out_err;

endmodule

### rtl/contingency_table_marginalizer.sv
// Count table marginalizer: sums a three-way table (x, y, z) over x, over y,
// or over x and y, selected by the mode register; mode 3 flags an error.
// Channels:
//   i_cell - cell requests, one Q24.8 count each, x fastest, then y, then z.
//   o_res  - result requests: Q36.8 sum, reduced-table index, last flag,
//            error flag. Zero or one result per cell.
//   i_cfg  - register writes (0 mode, 1 x_card, 2 y_card, 3 z_card); always
//            ready. Any write restarts the table walk. Write only when idle.
// Throughput: one cell per cycle while o_res keeps taking results. The over-y
// mode keeps a per-x partial sum in a RAM; its read-add-write loop closes
// through a bypass, so even x_card = 1 runs at full rate.
// A result passes the queue slot, then the execute stage with the RAM read,
// then the output register on its way to o_res.
// Reset: registers return to mode 0 with all cards 1, walk positions and the
// running sum clear; the partial sum RAM is not cleared, every entry is
// written at y = 0 before it is read. When o_res stalls, the output register,
// the execute stage and a two-entry queue fill, then i_cell.ready drops.
module contingency_table_marginalizer import ctm_pkg::*; #(
    parameter int MAX_CARD = CTM_MAX_CARD,
    parameter int MAX_Z    = CTM_MAX_Z
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctm_cell_if.sink     i_cell,
    ctm_cfg_if.sink      i_cfg,
    ctm_result_if.source o_res
);

    // front -> queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic restart;

    // queue -> back
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // front end: registers, table walk, per-cell classification
    ctm_front #(
        .MAX_CARD (MAX_CARD),
        .MAX_Z    (MAX_Z)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cell    (i_cell),
        .i_cfg     (i_cfg),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_cmd     (push_cmd),
        .o_restart (restart)
    );

    // decouples the walk from the accumulate/emit side
    ctm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // back end: accumulator, partial sum buffer, result register
    ctm_back #(
        .MAX_CARD (MAX_CARD)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule
